@@ rtl/assert_macros.svh @@
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lr_pkg.sv @@
// package: coordinate width, line mode codes and item kind codes for the line rasterizer
`default_nettype none
package lr_pkg;

    // default coordinate width in bits
    localparam int unsigned COORD_BITS = 10;

    // line class held while a line is active
    typedef enum logic [2:0] {
        MODE_VERT  = 3'd0,
        MODE_HORZ  = 3'd1,
        MODE_SH_UP = 3'd2,
        MODE_ST_UP = 3'd3,
        MODE_SH_DN = 3'd4,
        MODE_ST_DN = 3'd5
    } t_mode;

    // item kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

endpackage
`default_nettype wire

@@ rtl/lr_cmd_if.sv @@
// channel interfaces: line commands in, pixels out
`default_nettype none
interface lr_cmd_if #(
    parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lr_pix_if #(
    parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface
`default_nettype wire

@@ rtl/lr_engine.sv @@
// bresenham line state and one-pixel-per-item step logic
`default_nettype none
module lr_engine #(
    parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_kind,
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    output logic                       o_pixel_valid,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic                       o_last_pixel,
    output logic                       o_active
);
    import lr_pkg::*;

    localparam int unsigned DEC_BITS = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] CoordOne = COORD_BITS'(1);

    // line state
    logic                       r_active, n_active;
    logic [COORD_BITS-1:0]      r_cx, n_cx, r_cy, n_cy;
    logic [COORD_BITS-1:0]      r_tx, n_tx, r_ty, n_ty;
    logic [COORD_BITS-1:0]      r_dx, n_dx, r_dy, n_dy;
    logic signed [DEC_BITS-1:0] r_dec, n_dec;
    t_mode                      r_mode, n_mode;

    // start item: endpoints ordered so x does not decrease
    logic                  w_swap;
    logic [COORD_BITS-1:0] w_xa, w_ya, w_xb, w_yb;
    logic [COORD_BITS-1:0] w_sdx, w_sady;
    logic                  w_up;

    // step item helpers
    logic                  w_minor;
    logic [DEC_BITS-1:0]   w_tdx, w_tdy;
    logic [COORD_BITS-1:0] w_x_inc, w_y_inc, w_y_dec;

    assign w_swap  = i_x_end < i_x_start;
    assign w_xa    = w_swap ? i_x_end   : i_x_start;
    assign w_ya    = w_swap ? i_y_end   : i_y_start;
    assign w_xb    = w_swap ? i_x_start : i_x_end;
    assign w_yb    = w_swap ? i_y_start : i_y_end;
    assign w_sdx   = w_xb - w_xa;
    assign w_up    = w_yb > w_ya;
    assign w_sady  = w_up ? (w_yb - w_ya) : (w_ya - w_yb);

    assign w_minor = !r_dec[DEC_BITS-1];
    assign w_tdx   = {2'b00, r_dx, 1'b0};
    assign w_tdy   = {2'b00, r_dy, 1'b0};
    assign w_x_inc = r_cx + CoordOne;
    assign w_y_inc = r_cy + CoordOne;
    assign w_y_dec = r_cy - CoordOne;

    // next state and result
    always_comb begin
        n_active      = r_active;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_tx          = r_tx;
        n_ty          = r_ty;
        n_dx          = r_dx;
        n_dy          = r_dy;
        n_dec         = r_dec;
        n_mode        = r_mode;
        o_pixel_valid = 1'b0;
        o_pixel_x     = '0;
        o_pixel_y     = '0;
        o_last_pixel  = 1'b0;

        if (i_kind == KIND_START) begin
            n_dx  = w_sdx;
            n_dy  = w_sady;
            n_cx  = w_xa;
            n_cy  = w_ya;
            n_tx  = w_xb;
            n_ty  = w_yb;
            n_dec = '0;
            if (w_sdx == '0) begin
                n_mode = MODE_VERT;
                n_cy   = w_up ? w_ya : w_yb;
                n_ty   = w_up ? w_yb : w_ya;
            end else if (w_sady == '0) begin
                n_mode = MODE_HORZ;
            end else if (w_sady > w_sdx) begin
                n_mode = w_up ? MODE_ST_UP : MODE_ST_DN;
                n_dec  = $signed({2'b00, w_sdx, 1'b0} - {3'b000, w_sady});
            end else begin
                n_mode = w_up ? MODE_SH_UP : MODE_SH_DN;
                n_dec  = $signed({2'b00, w_sady, 1'b0} - {3'b000, w_sdx});
            end
            o_pixel_valid = 1'b1;
            o_last_pixel  = (w_xa == w_xb) && (w_ya == w_yb);
            n_active      = !o_last_pixel;
        end else if (r_active) begin
            o_pixel_valid = 1'b1;
            case (r_mode)
                MODE_VERT: begin
                    n_cy         = w_y_inc;
                    o_last_pixel = (r_cx == r_tx) && (w_y_inc == r_ty);
                end
                MODE_HORZ: begin
                    n_cx         = w_x_inc;
                    o_last_pixel = (w_x_inc == r_tx) && (r_cy == r_ty);
                end
                MODE_SH_UP, MODE_SH_DN: begin
                    n_cx  = w_x_inc;
                    if (w_minor) begin
                        n_cy = (r_mode == MODE_SH_UP) ? w_y_inc : w_y_dec;
                    end
                    n_dec = r_dec + $signed(w_minor ? (w_tdy - w_tdx) : w_tdy);
                    o_last_pixel = w_x_inc == r_tx;
                    if (o_last_pixel) begin
                        n_cy = r_ty;
                    end
                end
                MODE_ST_UP, MODE_ST_DN: begin
                    n_cy  = (r_mode == MODE_ST_UP) ? w_y_inc : w_y_dec;
                    if (w_minor) begin
                        n_cx = w_x_inc;
                    end
                    n_dec = r_dec + $signed(w_minor ? (w_tdx - w_tdy) : w_tdx);
                    o_last_pixel = n_cy == r_ty;
                    if (o_last_pixel) begin
                        n_cx = r_tx;
                    end
                end
                default: begin
                    o_pixel_valid = 1'b0;
                end
            endcase
            n_active = o_pixel_valid && !o_last_pixel;
        end

        if (o_pixel_valid) begin
            o_pixel_x = n_cx;
            o_pixel_y = n_cy;
        end
    end

    // state register, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_dec    <= '0;
            r_mode   <= MODE_VERT;
        end else if (i_adv) begin
            r_active <= n_active;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_dec    <= n_dec;
            r_mode   <= n_mode;
        end
    end

    assign o_active = r_active;

endmodule
`default_nettype wire

@@ rtl/line_rasterizer.sv @@
// line rasterizer top level: command register, step engine, pixel register
//
//  channel  dir  payload                                    handshake
//  i_cmd    in   kind, x_start, y_start, x_end, y_end       valid/ready
//  o_pix    out  pixel_valid, pixel_x, pixel_y, last_pixel  valid/ready
//
// every command gives exactly one pixel transfer, one command per cycle sustained while o_pix.ready stays high
// a command passes the command register, then the engine step into the pixel register
// the engine's line state updates in the same cycle the pixel register loads
// a held pixel stalls the command register, which stalls i_cmd only when both are full
// synchronous active-low reset clears the line state and both valid flags
`default_nettype none
`include "assert_macros.svh"
module line_rasterizer #(
    parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lr_cmd_if.sink    i_cmd,
    lr_pix_if.source  o_pix
);
    import lr_pkg::*;

    // command register
    logic                  r_in_valid, n_in_valid;
    logic                  r_in_kind;
    logic [COORD_BITS-1:0] r_in_xs, r_in_ys, r_in_xe, r_in_ye;

    // pixel register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_pv, r_out_last;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;

    // engine results
    logic                  w_res_pv, w_res_last, w_active;
    logic [COORD_BITS-1:0] w_res_x, w_res_y;

    logic w_accept, w_adv;

    // handshake
    assign w_adv       = r_in_valid && (!r_out_valid || o_pix.ready);
    assign i_cmd.ready = !r_in_valid || w_adv;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_in_valid  = w_accept ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = w_adv ? 1'b1 : (o_pix.ready ? 1'b0 : r_out_valid);
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // command payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= i_cmd.kind;
            r_in_xs   <= i_cmd.x_start;
            r_in_ys   <= i_cmd.y_start;
            r_in_xe   <= i_cmd.x_end;
            r_in_ye   <= i_cmd.y_end;
        end
    end

    lr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_kind        (r_in_kind),
        .i_x_start     (r_in_xs),
        .i_y_start     (r_in_ys),
        .i_x_end       (r_in_xe),
        .i_y_end       (r_in_ye),
        .o_pixel_valid (w_res_pv),
        .o_pixel_x     (w_res_x),
        .o_pixel_y     (w_res_y),
        .o_last_pixel  (w_res_last),
        .o_active      (w_active)
    );

    // pixel payload capture
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pv   <= w_res_pv;
            r_out_x    <= w_res_x;
            r_out_y    <= w_res_y;
            r_out_last <= w_res_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_valid = r_out_pv;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.last_pixel  = r_out_last;

    // checks
    `ASSERT_CLK(a_last_ends_line, i_clk, i_rst_n, (w_adv && w_res_last) |=> !w_active, "line still active after last pixel")
    `ASSERT_CLK(a_last_is_pixel, i_clk, i_rst_n, (r_out_valid && r_out_last) |-> r_out_pv, "last pixel flag without pixel")
    `ASSERT_CLK(a_empty_is_zero, i_clk, i_rst_n, (r_out_valid && !r_out_pv) |-> (r_out_x == '0 && r_out_y == '0 && !r_out_last), "empty result with nonzero fields")
    `ASSERT_ALWAYS(a_stall_cause, i_clk, !i_cmd.ready |-> (r_in_valid && r_out_valid && !o_pix.ready), "command stalled without a full pipeline")

endmodule
`default_nettype wire

@@ dv/line_rasterizer_check.sv @@
// line rasterizer checker: pixel prediction from accepted commands and in-order comparison
`default_nettype none
module line_rasterizer_check #(
    parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lr_cmd_if                i_cmd,
    lr_pix_if                i_pix,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending,
    output int unsigned      o_checked
);
    import lr_pkg::*;

    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } t_pixel;

    // predicted line walker state
    logic                  walk_active;
    logic [COORD_BITS-1:0] pos_x, pos_y, end_x, end_y;
    int                    run_x, rise_y, err_acc;
    t_mode                 walk_mode;

    t_pixel      pixels_due[$];
    int unsigned fail_count;
    int unsigned checked;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    // advance the walker by one command and return the pixel it should produce
    function automatic t_pixel next_pixel(input logic kind,
                                          input logic [COORD_BITS-1:0] xs, ys, xe, ye);
        t_pixel                px;
        logic [COORD_BITS-1:0] xa, ya, xb, yb, tmp;
        int                    dx, dy, ady;
        logic                  minor_step;
        logic                  done;
        px = '0;
        if (kind == KIND_START) begin
            xa = xs;
            ya = ys;
            xb = xe;
            yb = ye;
            // walk with x never decreasing
            if (xb < xa) begin
                tmp = xa; xa = xb; xb = tmp;
                tmp = ya; ya = yb; yb = tmp;
            end
            dx  = int'(xb) - int'(xa);
            dy  = int'(yb) - int'(ya);
            ady = (dy < 0) ? -dy : dy;
            run_x   = dx;
            rise_y  = ady;
            pos_x   = xa;
            pos_y   = ya;
            end_x   = xb;
            end_y   = yb;
            err_acc = 0;
            if (dx == 0) begin
                // vertical runs always go upward in y
                walk_mode = MODE_VERT;
                pos_y = (ya < yb) ? ya : yb;
                end_y = (ya < yb) ? yb : ya;
            end else if (dy == 0) begin
                walk_mode = MODE_HORZ;
            end else if (ady > dx) begin
                walk_mode = (dy > 0) ? MODE_ST_UP : MODE_ST_DN;
                err_acc   = 2 * dx - ady;
            end else begin
                walk_mode = (dy > 0) ? MODE_SH_UP : MODE_SH_DN;
                err_acc   = 2 * ady - dx;
            end
            walk_active = 1'b1;
            done = (pos_x == end_x) && (pos_y == end_y);
        end else begin
            if (!walk_active)
                return '0;
            minor_step = (err_acc >= 0);
            case (walk_mode)
                MODE_VERT: begin
                    pos_y = pos_y + 1'b1;
                    done  = (pos_x == end_x) && (pos_y == end_y);
                end
                MODE_HORZ: begin
                    pos_x = pos_x + 1'b1;
                    done  = (pos_x == end_x) && (pos_y == end_y);
                end
                MODE_SH_UP, MODE_SH_DN: begin
                    pos_x = pos_x + 1'b1;
                    if (minor_step)
                        pos_y = (walk_mode == MODE_SH_UP) ? pos_y + 1'b1 : pos_y - 1'b1;
                    err_acc += minor_step ? 2 * rise_y - 2 * run_x : 2 * rise_y;
                    // snap to the endpoint on the final column
                    done = (pos_x == end_x);
                    if (done)
                        pos_y = end_y;
                end
                MODE_ST_UP, MODE_ST_DN: begin
                    pos_y = (walk_mode == MODE_ST_UP) ? pos_y + 1'b1 : pos_y - 1'b1;
                    if (minor_step)
                        pos_x = pos_x + 1'b1;
                    err_acc += minor_step ? 2 * run_x - 2 * rise_y : 2 * run_x;
                    // snap to the endpoint on the final row
                    done = (pos_y == end_y);
                    if (done)
                        pos_x = end_x;
                end
                default: begin
                    walk_active = 1'b0;
                    return '0;
                end
            endcase
        end
        px.pixel_valid = 1'b1;
        px.pixel_x     = pos_x;
        px.pixel_y     = pos_y;
        px.last_pixel  = done;
        if (done)
            walk_active = 1'b0;
        return px;
    endfunction

    // one field of a pixel transfer against its prediction
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("pixel %0d: %s expected %0d, got %0d", checked, field, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        checked    = 0;
    end

    // compare pixel transfers first, then queue the prediction for a command transfer
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (!i_rst_n) begin
            walk_active = 1'b0;
            pos_x       = '0;
            pos_y       = '0;
            end_x       = '0;
            end_y       = '0;
            run_x       = 0;
            rise_y      = 0;
            err_acc     = 0;
            walk_mode   = MODE_VERT;
            pixels_due.delete();
        end else begin
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1) begin
                got.pixel_valid = i_pix.pixel_valid;
                got.pixel_x     = i_pix.pixel_x;
                got.pixel_y     = i_pix.pixel_y;
                got.last_pixel  = i_pix.last_pixel;
                if (pixels_due.size() == 0) begin
                    $error("pixel transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
                    check_field("pixel_x", want.pixel_x, got.pixel_x);
                    check_field("pixel_y", want.pixel_y, got.pixel_y);
                    check_field("last_pixel", want.last_pixel, got.last_pixel);
                    checked++;
                end
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1)
                pixels_due.push_back(next_pixel(i_cmd.kind, i_cmd.x_start, i_cmd.y_start,
                                                i_cmd.x_end, i_cmd.y_end));
        end
        o_pending <= pixels_due.size();
    end

endmodule
`default_nettype wire

@@ dv/line_rasterizer_test.sv @@
// line rasterizer testbench top: clock, reset, command stimulus, pixel back-pressure, verdict
`default_nettype none
module line_rasterizer_test;
    import lr_pkg::*;

    localparam int unsigned CB        = lr_pkg::COORD_BITS;
    localparam int          COORD_MAX = (1 << CB) - 1;
    localparam int          RANDOM_ITEMS = 1800;

    logic        clk;
    logic        rst_n;
    int          idle_pct;
    int          stall_pct;
    int          cmd_count;
    int          start_count;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    lr_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
    lr_pix_if #(.COORD_BITS(CB)) pix_ch ();

    line_rasterizer #(.COORD_BITS(CB)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_pix   (pix_ch)
    );

    line_rasterizer_check #(.COORD_BITS(CB)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_pix        (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("line_rasterizer_test failed");
        $finish;
    end

    // pixel back-pressure
    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            pix_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int clip(input int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // one command transfer, with a random sender gap ahead of it
    task automatic send_cmd(input logic kind, input int xs, ys, xe, ye);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.kind    <= kind;
        cmd_ch.x_start <= xs[CB-1:0];
        cmd_ch.y_start <= ys[CB-1:0];
        cmd_ch.x_end   <= xe[CB-1:0];
        cmd_ch.y_end   <= ye[CB-1:0];
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        cmd_count++;
        if (kind == KIND_START)
            start_count++;
    endtask

    // step command; the coordinate fields carry junk that must be ignored
    task automatic send_step();
        send_cmd(KIND_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic draw_line(input int xs, ys, xe, ye, input int steps);
        send_cmd(KIND_START, xs, ys, xe, ye);
        repeat (steps) send_step();
    endtask

    // hold off until every predicted pixel has been transferred
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly complete lines of modest length; some cut short, some overrun
    task automatic random_line();
        int xs, ys, xe, ye, span, shape, steps, tail;
        shape = $urandom_range(9);
        span  = ($urandom_range(39) == 0) ? 200 : 14;
        xs = $urandom_range(COORD_MAX);
        ys = $urandom_range(COORD_MAX);
        xe = clip(xs + int'($urandom_range(2 * span)) - span);
        ye = clip(ys + int'($urandom_range(2 * span)) - span);
        if (shape == 0 || shape == 2)
            xe = xs;
        if (shape == 1 || shape == 2)
            ye = ys;
        steps = (abs_diff(xs, xe) > abs_diff(ys, ye)) ? abs_diff(xs, xe) : abs_diff(ys, ye);
        tail  = $urandom_range(9);
        if (tail == 0)
            steps = $urandom_range(steps);
        else if (tail == 1)
            steps += $urandom_range(3, 1);
        draw_line(xs, ys, xe, ye, steps);
    endtask

    initial begin
        int phase;
        int target;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.kind    <= KIND_START;
        cmd_ch.x_start <= '0;
        cmd_ch.y_start <= '0;
        cmd_ch.x_end   <= '0;
        cmd_ch.y_end   <= '0;
        rst_n          <= 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        cmd_count   = 0;
        start_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle step, single points, each line class, overrun, abandoned line
        send_step();
        send_cmd(KIND_START, 0, 0, 0, 0);
        send_cmd(KIND_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_step();
        draw_line(5, 9, 5, 7, 2);
        draw_line(COORD_MAX, 0, COORD_MAX - 2, 0, 2);
        draw_line(0, COORD_MAX, 3, COORD_MAX - 2, 3);
        draw_line(0, 0, 1, 3, 3);
        send_step();
        draw_line(2, 0, 0, 3, 3);
        draw_line(0, 0, COORD_MAX, COORD_MAX, 1);
        draw_line(COORD_MAX, 0, 0, COORD_MAX, 2);
        drain();

        // random: four pacing phases, fully drained between them
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            target = cmd_count + RANDOM_ITEMS / 4;
            while (cmd_count < target) begin
                if ($urandom_range(9) != 0)
                    random_line();
                else if ($urandom_range(1) == 0)
                    send_step();
                else
                    draw_line($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                              $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                              $urandom_range(3));
            end
            drain();
        end
        repeat (20) @(posedge clk);

        $display("covered %0d commands (%0d line starts) over four pacing phases", cmd_count,
                 start_count);
        $display("%0d pixel transfers compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("line_rasterizer_test passed");
        else
            $display("line_rasterizer_test failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_cmd_if.sv
rtl/lr_engine.sv
rtl/line_rasterizer.sv
dv/line_rasterizer_check.sv
dv/line_rasterizer_test.sv
